@@ rtl/smd_pkg.sv @@
// Shared types for the saturating multiply-divide block.
`default_nettype none
package smd_pkg;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} au_op_t;

	typedef struct packed {
		logic   start;
		au_op_t op;
	} au_ctl_t;

	typedef struct packed {
		logic done;
	} au_sts_t;

endpackage
`default_nettype wire

@@ rtl/smd_arith.sv @@
// Shared iterative unit: shift-add multiplier and restoring divider, one bit per cycle.
`default_nettype none
module smd_arith #(
	parameter int W = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire smd_pkg::au_ctl_t ctl,
	input  wire logic [W-1:0]   opa,
	input  wire logic [W-1:0]   opb,
	output smd_pkg::au_sts_t    sts,
	output logic [W-1:0]        res_hi,
	output logic [W-1:0]        res_lo
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  hi_q;
	logic [W-1:0]  lo_q;
	logic [W-1:0]  opd_q;
	smd_pkg::au_op_t op_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]    mul_sum;
	logic [W:0]    div_t;
	logic          div_ge;
	logic [W:0]    div_diff;

	always_comb begin
		mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, opd_q} : {(W+1){1'b0}});
		div_t    = {hi_q, lo_q[W-1]};
		div_ge   = div_t >= {1'b0, opd_q};
		div_diff = div_t - {1'b0, opd_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= smd_pkg::OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q  <= CW'(W);
				busy_q <= 1'b1;
				op_q   <= ctl.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			hi_q <= '0;
			if (ctl.op == smd_pkg::OP_MUL) begin
				lo_q  <= opb;
				opd_q <= opa;
			end else begin
				lo_q  <= opa;
				opd_q <= opb;
			end
		end else if (busy_q) begin
			case (op_q)
				smd_pkg::OP_MUL: begin
					hi_q <= mul_sum[W:1];
					lo_q <= {mul_sum[0], lo_q[W-1:1]};
				end
				smd_pkg::OP_DIV: begin
					// remainder stays below the divisor, so W bits hold it
					hi_q <= div_ge ? div_diff[W-1:0] : div_t[W-1:0];
					lo_q <= {lo_q[W-2:0], div_ge};
				end
				default: begin
					hi_q <= hi_q;
				end
			endcase
		end
	end

	assign sts.done = done_q;
	assign res_hi   = hi_q;
	assign res_lo   = lo_q;

endmodule
`default_nettype wire

@@ rtl/saturating_mul_div_u64.sv @@
// Top level of the saturating multiply-divide block.
`default_nettype none
// Returns an approximation of a*b/d at DATA_WIDTH bits, saturating to all ones; a zero
// divisor gives all ones and a zero factor gives zero. All multiplies and divides run
// through one shared unit that multiplies or divides one bit per cycle. An item takes
// one pass per Euclid step of both gcd reductions and four reduction divisions. After
// that it takes a single multiply when the reduced divisor is one. Otherwise it takes a
// split division and a high product multiply when the quotient is nonzero, then, while
// a remainder is left, one multiply per residual check with a halving after each one
// that overflows, and a final division. The number of passes is data dependent. The
// block accepts no new item until its result has transferred.
module saturating_mul_div_u64 #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] multiplicand_a,
	input  wire logic [63:0] multiplicand_b,
	input  wire logic [63:0] divisor,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      quotient
);

	localparam int W = DATA_WIDTH;

	typedef enum logic [3:0] {
		S_IDLE, S_G1, S_G1W, S_RB, S_RD1, S_G2, S_G2W, S_RA, S_RD2,
		S_MAB, S_DAD, S_MQB, S_RCHK, S_MRB, S_DLO, S_DONE
	} state_t;

	state_t state_q;
	logic [W-1:0] a_q, b_q, d_q, x_q, y_q, r_q, hi_q, res_q, opa_q, opb_q;
	smd_pkg::au_ctl_t ctl_q;
	smd_pkg::au_sts_t sts;
	logic [W-1:0] u_hi, u_lo;

	logic [W-1:0] ai, bi, di, d_half;
	logic [W:0]   sum;
	localparam logic [W-1:0] TOP = {W{1'b1}};

	assign ai     = multiplicand_a[W-1:0];
	assign bi     = multiplicand_b[W-1:0];
	assign di     = divisor[W-1:0];
	assign d_half = (d_q >> 1) == '0 ? W'(1) : (d_q >> 1);
	assign sum    = {1'b0, hi_q} + {1'b0, u_lo};

	smd_arith #(.W(W)) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_q),
		.opa    (opa_q),
		.opb    (opb_q),
		.sts    (sts),
		.res_hi (u_hi),
		.res_lo (u_lo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ctl_q   <= '{start: 1'b0, op: smd_pkg::OP_MUL};
		end else begin
			ctl_q.start <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) begin
					if (di == '0) state_q <= S_DONE;
					else if (ai == '0 || bi == '0) state_q <= S_DONE;
					else state_q <= S_G1;
				end
				S_G1: begin
					ctl_q <= '{start: 1'b1, op: smd_pkg::OP_DIV};
					state_q <= (y_q == '0) ? S_RB : S_G1W;
				end
				S_G1W: if (sts.done) state_q <= S_G1;
				S_RB: if (sts.done) begin
					ctl_q <= '{start: 1'b1, op: smd_pkg::OP_DIV};
					state_q <= S_RD1;
				end
				S_RD1: if (sts.done) state_q <= S_G2;
				S_G2: begin
					ctl_q <= '{start: 1'b1, op: smd_pkg::OP_DIV};
					state_q <= (y_q == '0) ? S_RA : S_G2W;
				end
				S_G2W: if (sts.done) state_q <= S_G2;
				S_RA: if (sts.done) begin
					ctl_q <= '{start: 1'b1, op: smd_pkg::OP_DIV};
					state_q <= S_RD2;
				end
				S_RD2: if (sts.done) begin
					if (u_lo == W'(1)) begin
						ctl_q <= '{start: 1'b1, op: smd_pkg::OP_MUL};
						state_q <= S_MAB;
					end else begin
						ctl_q <= '{start: 1'b1, op: smd_pkg::OP_DIV};
						state_q <= S_DAD;
					end
				end
				S_MAB: if (sts.done) state_q <= S_DONE;
				S_DAD: if (sts.done) begin
					if (u_lo != '0) begin
						ctl_q <= '{start: 1'b1, op: smd_pkg::OP_MUL};
						state_q <= S_MQB;
					end else begin
						state_q <= S_RCHK;
					end
				end
				S_MQB: if (sts.done) state_q <= (u_hi != '0) ? S_DONE : S_RCHK;
				S_RCHK: begin
					if (r_q == '0) begin
						state_q <= S_DONE;
					end else begin
						ctl_q <= '{start: 1'b1, op: smd_pkg::OP_MUL};
						state_q <= S_MRB;
					end
				end
				S_MRB: if (sts.done) begin
					if (u_hi != '0) begin
						state_q <= S_RCHK;
					end else begin
						ctl_q <= '{start: 1'b1, op: smd_pkg::OP_DIV};
						state_q <= S_DLO;
					end
				end
				S_DLO: if (sts.done) state_q <= S_DONE;
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers follow the sequencer's decisions above
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				a_q <= ai; b_q <= bi; d_q <= di; x_q <= bi; y_q <= di;
				res_q <= (di == '0) ? TOP : '0;
			end
			S_G1, S_G2: begin
				if (y_q == '0) begin
					opa_q <= (state_q == S_G1) ? b_q : a_q;
					opb_q <= x_q;
				end else begin
					opa_q <= x_q;
					opb_q <= y_q;
				end
			end
			S_G1W, S_G2W: if (sts.done) begin
				x_q <= y_q;
				y_q <= u_hi;
			end
			S_RB, S_RA: if (sts.done) begin
				if (state_q == S_RB) b_q <= u_lo;
				else a_q <= u_lo;
				opa_q <= d_q;
				opb_q <= x_q;
			end
			S_RD1: if (sts.done) begin
				d_q <= u_lo; x_q <= a_q; y_q <= u_lo;
			end
			S_RD2: if (sts.done) begin
				d_q   <= u_lo;
				opa_q <= a_q;
				opb_q <= (u_lo == W'(1)) ? b_q : u_lo;
			end
			S_MAB: if (sts.done) res_q <= (u_hi != '0) ? TOP : u_lo;
			S_DAD: if (sts.done) begin
				r_q   <= u_hi;
				hi_q  <= '0;
				opa_q <= u_lo;
				opb_q <= b_q;
			end
			S_MQB: if (sts.done) begin
				hi_q  <= u_lo;
				res_q <= TOP;
			end
			S_RCHK: begin
				res_q <= hi_q;
				opa_q <= r_q;
				opb_q <= b_q;
			end
			S_MRB: if (sts.done) begin
				if (u_hi != '0) begin
					// shrink the larger factor together with the divisor
					if (r_q >= b_q) r_q <= r_q >> 1;
					else b_q <= b_q >> 1;
					d_q <= d_half;
				end else begin
					opa_q <= u_lo;
					opb_q <= d_q;
				end
			end
			S_DLO: if (sts.done) res_q <= sum[W] ? TOP : sum[W-1:0];
			default: res_q <= res_q;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign quotient  = 64'(res_q);

endmodule
`default_nettype wire

@@ rtl/smd_checker.sv @@
// Port-level checker for the saturating multiply-divide block, bound to the top level.
`default_nettype none
module smd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] quotient
);

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready again right after an input transfer");

	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready && !out_valid)
		else $error("not idle after the result transfer");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quotient))
		else $error("stalled result dropped or changed");

endmodule

bind saturating_mul_div_u64 smd_checker u_smd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.quotient  (quotient)
);
`default_nettype wire
